// ----- design/phd_pkg.sv -----
// Package for the ADC pulse height detector: shared types, widths, register
// indexes and the tolerance compare used by the window cells.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package phd_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int RAW_W     = 16;
  localparam int LEN_W     = 4;
  localparam int TOL_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam logic [SAMPLE_W-1:0] SAMPLE_SUBST = 12'd2048;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd2;

  localparam logic [SAMPLE_W-1:0] RST_MIN_HEIGHT = 12'd50;
  localparam logic [LEN_W-1:0]    RST_MAX_LENGTH = 4'd10;
  localparam logic [TOL_W-1:0]    RST_TOLERANCE  = 4'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] min_height;
    logic [LEN_W-1:0]    max_length;
    logic [TOL_W-1:0]    tolerance;
  } phd_cfg_t;

  // Status of the sample window handed to the pulse unit for one request.
  typedef struct packed {
    logic eval;       // a current sample exists
    logic full;       // the whole window has been filled since reset
    logic near_cur;   // current sample within tolerance of the baseline
    logic near_new;   // newest sample within tolerance of the baseline
    logic flat;       // all past samples within tolerance of the current one
  } phd_win_stat_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] peak_height;
    logic [LEN_W-1:0]    pulse_length;
    logic [SAMPLE_W-1:0] pulse_baseline;
  } phd_result_t;

  // True when a lies within tol of ref_val.
  function automatic logic phd_near(input logic [SAMPLE_W-1:0] a,
                                    input logic [SAMPLE_W-1:0] ref_val,
                                    input logic [TOL_W-1:0]    tol);
    logic [SAMPLE_W-1:0] diff;
    diff = (a >= ref_val) ? (a - ref_val) : (ref_val - a);
    return diff <= {{(SAMPLE_W-TOL_W){1'b0}}, tol};
  endfunction

endpackage

// ----- design/phd_if.sv -----
// Handshake channel interfaces of the pulse height detector: sample input,
// pulse result output and configuration write port. Depend on phd_pkg.
`timescale 1ns / 1ps

interface phd_in_if;
  import phd_pkg::*;
  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface phd_out_if;
  import phd_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] peak_height;
  logic [LEN_W-1:0]    pulse_length;
  logic [SAMPLE_W-1:0] pulse_baseline;
  modport source (output valid, output peak_height, output pulse_length,
                  output pulse_baseline, input ready);
  modport sink   (input valid, input peak_height, input pulse_length,
                  input pulse_baseline, output ready);
endinterface

interface phd_cfg_if;
  import phd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/phd_win_cell.sv -----
// One cell of the sample window: holds one sample, passes it to its older
// neighbor on each request and checks the incoming sample against a reference.
// Depends on phd_pkg.
`timescale 1ns / 1ps

module phd_win_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [phd_pkg::SAMPLE_W-1:0] d_in,
  input  logic [phd_pkg::SAMPLE_W-1:0] ref_val,
  input  logic [phd_pkg::TOL_W-1:0]    tol,
  output logic [phd_pkg::SAMPLE_W-1:0] q,
  output logic                         near
);
  import phd_pkg::*;

  logic [SAMPLE_W-1:0] value_r;

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= d_in;
    end
  end

  assign q    = value_r;
  assign near = phd_near(d_in, ref_val, tol);

endmodule

// ----- design/phd_pulse_unit.sv -----
// Baseline tracking and pulse measurement for the pulse height detector.
// Holds baseline, pulse flag, age and peak; depends on phd_pkg.
`timescale 1ns / 1ps

module phd_pulse_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  phd_pkg::phd_cfg_t             cfg,
  input  phd_pkg::phd_win_stat_t        stat,
  input  logic [phd_pkg::SAMPLE_W-1:0]  cur,
  output logic [phd_pkg::SAMPLE_W-1:0]  baseline,
  output logic                          res_valid,
  output phd_pkg::phd_result_t          res
);
  import phd_pkg::*;

  logic [SAMPLE_W-1:0] base_r, base_nxt;
  logic                pulse_r, pulse_nxt;
  logic [LEN_W-1:0]    age_r, age_nxt;
  logic [SAMPLE_W-1:0] peak_r, peak_nxt;
  logic [SAMPLE_W:0]   level;

  always_comb begin
    base_nxt  = base_r;
    pulse_nxt = pulse_r;
    age_nxt   = age_r;
    peak_nxt  = peak_r;
    res_valid = 1'b0;
    res.peak_height    = peak_r - base_r;
    res.pulse_length   = age_r + 1'b1;
    res.pulse_baseline = base_r;
    if (stat.eval) begin
      if (!pulse_r && !stat.near_cur && !stat.near_new && stat.full && stat.flat) begin
        base_nxt = cur;
      end
      level = {1'b0, base_nxt} + {1'b0, cfg.min_height};
      if (base_nxt != '0) begin
        if (!pulse_r) begin
          if ({1'b0, cur} >= level) begin
            pulse_nxt = 1'b1;
            age_nxt   = '0;
            peak_nxt  = cur;
          end
        end else begin
          age_nxt = age_r + 1'b1;
          if ({1'b0, cur} < level) begin
            // Falling edge of the pulse: report it.
            pulse_nxt = 1'b0;
            res_valid = 1'b1;
          end else if (age_nxt >= cfg.max_length) begin
            // Too long: drop the run without a result.
            pulse_nxt = 1'b0;
          end else if (cur > peak_r) begin
            peak_nxt = cur;
          end
        end
      end
    end else begin
      level = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      pulse_r <= 1'b0;
      age_r   <= '0;
      peak_r  <= '0;
    end else if (en) begin
      base_r  <= base_nxt;
      pulse_r <= pulse_nxt;
      age_r   <= age_nxt;
      peak_r  <= peak_nxt;
    end
  end

  assign baseline = base_r;

endmodule

// ----- design/adc_pulse_height_detector.sv -----
// Top level of the ADC pulse height detector: window cell chain, pulse unit,
// configuration registers and a two-entry result buffer.
// Depends on phd_pkg, phd_if, phd_win_cell and phd_pulse_unit.
`timescale 1ns / 1ps

// Channel   Direction  Payload                                        Handshake
// in_ch     sink       sample[15:0]                                   valid/ready
// out_ch    source     peak_height[11:0] pulse_length[3:0]
//                      pulse_baseline[11:0]                           valid/ready
// cfg_ch    sink       index[1:0] data[11:0]                          valid/ready
//
// One sample request is taken every clock cycle; the result buffer sets this
// rate: with two entries it only stalls in_ch while both hold unread results.
// The window shift, baseline tracking and pulse decision all settle in the
// cycle of the request; a result is written to the buffer that drives out_ch.
// Reset (rst_n low, synchronous) empties the window fill count, the baseline,
// the pulse state and the result buffer, and loads the register defaults.
// cfg_ch is always ready; registers must only be written while the block is idle.

module adc_pulse_height_detector #(
  parameter int LOOKAHEAD = 10,
  parameter int HISTORY   = 3
) (
  input logic        clk,
  input logic        rst_n,
  phd_in_if.sink     in_ch,
  phd_out_if.source  out_ch,
  phd_cfg_if.sink    cfg_ch
);
  import phd_pkg::*;

  // The window holds LOOKAHEAD newer samples, the current one and HISTORY
  // older ones. Cell 0 takes the newest sample.
  localparam int DEPTH  = LOOKAHEAD + HISTORY + 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  // Configuration registers.
  phd_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_height <= RST_MIN_HEIGHT;
      cfg_r.max_length <= RST_MAX_LENGTH;
      cfg_r.tolerance  <= RST_TOLERANCE;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_MIN_HEIGHT: cfg_r.min_height <= cfg_ch.data;
        REG_MAX_LENGTH: cfg_r.max_length <= cfg_ch.data[LEN_W-1:0];
        REG_TOLERANCE:  cfg_r.tolerance  <= cfg_ch.data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Result buffer state; in_ch is ready while it has a free entry.
  phd_result_t    buf_r [2];
  logic           rd_ptr_r, wr_ptr_r;
  logic [1:0]     cnt_r;
  logic           accept;
  logic           push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign accept      = in_ch.valid && in_ch.ready;

  // Out-of-range samples are replaced before they enter the window.
  logic [SAMPLE_W-1:0] clamped;
  assign clamped = (in_ch.sample[RAW_W-1:SAMPLE_W] != '0) ? SAMPLE_SUBST
                                                          : in_ch.sample[SAMPLE_W-1:0];

  // Fill count of the window, saturating at the window depth.
  logic [FILL_W-1:0] fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept && (fill_r != FILL_W'(DEPTH))) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  // Cell chain. Each cell compares the sample it is about to take: the
  // newest, the lookahead and the current cells against the baseline, the past cells
  // against the current sample.
  logic [SAMPLE_W-1:0] cell_d    [DEPTH];
  logic [SAMPLE_W-1:0] cell_q    [DEPTH];
  logic [SAMPLE_W-1:0] cell_ref  [DEPTH];
  logic                cell_near [DEPTH];
  logic [SAMPLE_W-1:0] baseline;
  logic [SAMPLE_W-1:0] cur;

  assign cur = cell_d[LOOKAHEAD];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_d[i] = clamped;
    end else begin : g_link
      assign cell_d[i] = cell_q[i-1];
    end
    assign cell_ref[i] = (i > LOOKAHEAD) ? cur : baseline;

    phd_win_cell u_cell (
      .clk     (clk),
      .en      (accept),
      .d_in    (cell_d[i]),
      .ref_val (cell_ref[i]),
      .tol     (cfg_r.tolerance),
      .q       (cell_q[i]),
      .near    (cell_near[i])
    );
  end

  phd_win_stat_t stat;

  always_comb begin
    stat.eval     = (fill_r >= FILL_W'(LOOKAHEAD));
    stat.full     = (fill_r >= FILL_W'(DEPTH - 1));
    stat.near_cur = cell_near[LOOKAHEAD];
    stat.near_new = cell_near[0];
    stat.flat     = 1'b1;
    for (int h = LOOKAHEAD + 1; h < DEPTH; h++) begin
      stat.flat = stat.flat & cell_near[h];
    end
  end

  logic        res_valid;
  phd_result_t res;

  phd_pulse_unit u_pulse (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (accept),
    .cfg       (cfg_r),
    .stat      (stat),
    .cur       (cur),
    .baseline  (baseline),
    .res_valid (res_valid),
    .res       (res)
  );

  // Two-entry result buffer between the pulse unit and out_ch.
  assign push = accept && res_valid;
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign out_ch.valid          = (cnt_r != 2'd0);
  assign out_ch.peak_height    = buf_r[rd_ptr_r].peak_height;
  assign out_ch.pulse_length   = buf_r[rd_ptr_r].pulse_length;
  assign out_ch.pulse_baseline = buf_r[rd_ptr_r].pulse_baseline;

endmodule
